### src/sps_pkg.sv
// Shared types and constants for the masked positive sort block.
// No dependencies; every other file in src imports this package.
package sps_pkg;

    localparam int DATA_W      = 32;
    localparam int MAX_LEN_DEF = 64;

    // Input item
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     overflow;
    } t_out_item;

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } t_state;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic signed [DATA_W-1:0] value;      // element being stored
        logic                     load;       // element is stored this cycle
        logic                     ins;        // element is positive and stored
        logic                     emit;       // a result transfers this cycle
        logic                     sort_shift; // the result used a sorted entry
    } t_cell_ctl;

    // Link toward the higher-index neighbor: insertion data
    typedef struct packed {
        logic                     gt;  // this entry is empty or above the new value
        logic                     sv;  // sorted entry valid
        logic signed [DATA_W-1:0] s;   // sorted entry
    } t_sort_fwd;

    // Link toward the lower-index neighbor: drain data
    typedef struct packed {
        logic                     sv;
        logic signed [DATA_W-1:0] s;
        logic signed [DATA_W-1:0] k;   // kept element
        logic                     m;   // kept element was positive
    } t_emit_back;

endpackage

### src/sps_cell.sv
// One cell of the sort chain: one sorted entry, one kept element and its mask.
// Depends on sps_pkg for the control and neighbor link structs.
module sps_cell
    import sps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic       i_wr_here,
    input  t_sort_fwd  i_left,
    input  t_emit_back i_right,
    output t_sort_fwd  o_fwd,
    output t_emit_back o_back
);

    logic                     r_sv, r_m;
    logic signed [DATA_W-1:0] r_s, r_k;
    logic                     n_sv, n_m;
    logic signed [DATA_W-1:0] n_s, n_k;
    logic                     gt;

    // Compare own entry against the incoming value
    assign gt = !r_sv || (r_s > i_ctl.value);

    // Insert, shift up, or drain toward the output
    always_comb begin
        n_sv = r_sv;
        n_s  = r_s;
        n_k  = r_k;
        n_m  = r_m;
        if (i_ctl.ins) begin
            if (i_left.gt) begin
                n_sv = i_left.sv;
                n_s  = i_left.s;
            end else if (gt) begin
                n_sv = 1'b1;
                n_s  = i_ctl.value;
            end
        end
        if (i_ctl.load && i_wr_here) begin
            n_k = i_ctl.value;
            n_m = i_ctl.ins;
        end
        if (i_ctl.emit) begin
            n_k = i_right.k;
            n_m = i_right.m;
            if (i_ctl.sort_shift) begin
                n_sv = i_right.sv;
                n_s  = i_right.s;
            end
        end
    end

    // Clear flags under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_m  <= 1'b0;
        end else begin
            r_sv <= n_sv;
            r_m  <= n_m;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_k <= n_k;
    end

    assign o_fwd  = '{gt: gt, sv: r_sv, s: r_s};
    assign o_back = '{sv: r_sv, s: r_s, k: r_k, m: r_m};

endmodule

### src/sort_positives_in_place_top.sv
// Top level of the masked positive sort: sequencer and a chain of sps_cell.
// Depends on sps_pkg and sps_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one list
//   element per cycle while loading. The element with last set closes the
//   list. Up to MAX_LEN elements are stored; later ones are dropped and the
//   overflow bit is set on every result of that list.
//   Output channel (o_out_valid / i_out_stall / o_out_item) then delivers one
//   result per position in original order; positive positions carry the
//   positives in ascending order, others their original value.
//   The first result is valid the cycle after the last element's transfer.
//   The input stalls for the whole output phase since the cell chain drains
//   through cell 0.
//   Each stored positive is inserted into the sorted chain in the cycle it arrives
//   by a compare in every cell in parallel.
//   Reset clears the mask and valid flags of all cells and returns to loading;
//   no clearing pass is needed.
//   A stall on the output holds the chain and the presented result.
module sort_positives_in_place_top
    import sps_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;

    logic       in_acc, out_acc, room, pos;
    t_cell_ctl  ctl;
    t_sort_fwd  fwd  [MAX_LEN+1];
    t_emit_back back [MAX_LEN+1];

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign room    = r_count < CNT_W'(MAX_LEN);
    assign pos     = !i_in_item.value[DATA_W-1] && (|i_in_item.value);

    // Broadcast control to the chain
    always_comb begin
        ctl.value      = i_in_item.value;
        ctl.load       = in_acc && room;
        ctl.ins        = in_acc && room && pos;
        ctl.emit       = out_acc;
        ctl.sort_shift = out_acc && back[0].m;
    end

    // Chain boundaries
    assign fwd[0]        = '{gt: 1'b0, sv: 1'b0, s: '0};
    assign back[MAX_LEN] = '{sv: 1'b0, s: '0, k: '0, m: 1'b0};

    // Build the cell chain
    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        sps_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (ctl),
            .i_wr_here (r_count == CNT_W'(g)),
            .i_left    (fwd[g]),
            .i_right   (back[g+1]),
            .o_fwd     (fwd[g+1]),
            .o_back    (back[g])
        );
    end

    // Next state: load elements, then drain the list
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_ovf      = r_ovf;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                if (in_acc) begin
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_item.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_LOAD;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Present the head of the chain
    assign o_out_valid          = (r_state == S_EMIT);
    assign o_out_item.value_res = back[0].m ? back[0].s : back[0].k;
    assign o_out_item.last_res  = (r_count == CNT_W'(1));
    assign o_out_item.overflow  = r_ovf;

    // A list being drained is never empty
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_count != '0)
        else $error("drain phase with empty list");

    // A positive position always finds a sorted entry at the head
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && back[0].m) |-> back[0].sv)
        else $error("positive position without sorted entry");

    // Store count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LEN))
        else $error("item count above capacity");

    // Final result returns to loading with overflow cleared
    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_item.last_res) |=> (r_state == S_LOAD && !r_ovf && r_count == '0))
        else $error("list end did not restart loading");

    // First and last sorted entries empty after the last transfer
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_item.last_res) |=> !back[0].sv && !fwd[MAX_LEN].sv)
        else $error("sorted entries left after list end");

endmodule

### tb/tb_top.sv
// Self-checking testbench for sort_positives_in_place_top; depends on sps_pkg
// and the RTL in src. Drives directed and random lists with random handshake
// gaps and checks every result against an in-bench model or a typed expected value.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sps_pkg::*;

    localparam int LIST_CAP   = MAX_LEN_DEF;
    localparam int RAND_ITEMS = 450;
    localparam int MAX_REPORT = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    sort_positives_in_place_top #(
        .MAX_LEN(LIST_CAP)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    // Clock: 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Model of the block: kept list, sorted positives, and the list bookkeeping
    logic signed [DATA_W-1:0] mdl_sorted [0:63];
    logic signed [DATA_W-1:0] mdl_kept   [0:63];
    bit                       mdl_posmask[0:63];
    int                       mdl_count;
    int                       mdl_pos_count;
    bit                       mdl_dropped;

    // Results of the list just closed by the model
    t_out_item emitted [0:63];
    int        emitted_n;

    // Results still to come from the block, oldest first
    t_out_item expected_list_out[$];

    int  errors;
    int  tx_calm;
    int  rx_calm;

    typedef struct {
        t_in_item                 item;
        bit                       typed;
        logic signed [DATA_W-1:0] exp_value;
    } t_row;

    t_row directed_rows[$];

    // Store or drop one element; on the last one build the rearranged list
    task automatic sort_list_element(input t_in_item it);
        int p;
        int k;
        int i;
        int j;
        logic signed [DATA_W-1:0] r;
        emitted_n = 0;
        if (mdl_count < LIST_CAP) begin
            mdl_kept[mdl_count]    = it.value;
            mdl_posmask[mdl_count] = (it.value > 0);
            if (it.value > 0) begin
                p = 0;
                while (p < mdl_pos_count && mdl_sorted[p] <= it.value)
                    p++;
                for (k = mdl_pos_count; k > p; k--)
                    mdl_sorted[k] = mdl_sorted[k-1];
                mdl_sorted[p] = it.value;
                mdl_pos_count++;
            end
            mdl_count++;
        end else begin
            mdl_dropped = 1'b1;
        end
        if (it.last) begin
            j = 0;
            for (i = 0; i < mdl_count; i++) begin
                if (mdl_posmask[i]) begin
                    r = mdl_sorted[j];
                    j++;
                end else begin
                    r = mdl_kept[i];
                end
                emitted[i] = '{value_res: r, last_res: (i == mdl_count - 1),
                               overflow: mdl_dropped};
            end
            emitted_n = mdl_count;
            for (i = 0; i < 64; i++)
                mdl_posmask[i] = 1'b0;
            mdl_count     = 0;
            mdl_pos_count = 0;
            mdl_dropped   = 1'b0;
        end
    endtask

    // Draw a random wait length, with calm stretches of no waiting
    task automatic draw_wait(inout int calm, output int w);
        if (calm == 0 && $urandom_range(0, 5) == 0)
            calm = $urandom_range(10, 40);
        if (calm > 0) begin
            calm--;
            w = 0;
        end else begin
            w = $urandom_range(0, 11);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] draw_value();
        logic [DATA_W-1:0] u;
        u = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(1, 20);
            4:          return -$signed(DATA_W'($urandom_range(1, 20)));
            5:          return '0;
            6:          return u;
            7:          return u[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            8:          return (u[30:0] == 0) ? 32'sd1 : {1'b0, u[30:0]};
            default:    return {1'b1, u[30:0]};
        endcase
    endfunction

    task automatic add_row(input logic signed [DATA_W-1:0] v, input bit lst,
                           input bit typed, input logic signed [DATA_W-1:0] ev);
        t_row r;
        r.item.value = v;
        r.item.last  = lst;
        r.typed      = typed;
        r.exp_value  = ev;
        directed_rows.push_back(r);
    endtask

    // Present one element and hold it until the block takes it
    task automatic send_element(input t_in_item it);
        int gap;
        draw_wait(tx_calm, gap);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic queue_model_results();
        int i;
        for (i = 0; i < emitted_n; i++)
            expected_list_out.push_back(emitted[i]);
    endtask

    // Stimulus: reset, directed rows, then random lists
    initial begin
        int sent;
        int list_no;
        int len;
        int k;
        int i;
        t_in_item it;
        t_out_item typed_res;

        in_valid    = 1'b0;
        in_item     = '0;
        out_stall   = 1'b0;
        i_rst_n     = 1'b0;
        errors      = 0;
        tx_calm     = 0;
        rx_calm     = 0;
        mdl_count     = 0;
        mdl_pos_count = 0;
        mdl_dropped   = 1'b0;
        for (i = 0; i < 64; i++) begin
            mdl_sorted[i]  = '0;
            mdl_kept[i]    = '0;
            mdl_posmask[i] = 1'b0;
        end

        // One-element lists at the extremes and around zero come back unchanged
        add_row(32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF);
        add_row(32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000);
        add_row(32'sd0,         1'b1, 1'b1, 32'sd0);
        add_row(32'sd1,         1'b1, 1'b1, 32'sd1);
        add_row(-32'sd1,        1'b1, 1'b1, -32'sd1);
        // Mixed list with equal positives and both extremes
        add_row(32'sd5,         1'b0, 1'b0, '0);
        add_row(-32'sd3,        1'b0, 1'b0, '0);
        add_row(32'sd0,         1'b0, 1'b0, '0);
        add_row(32'sd2,         1'b0, 1'b0, '0);
        add_row(32'sd7,         1'b0, 1'b0, '0);
        add_row(32'sd2,         1'b0, 1'b0, '0);
        add_row(32'sh7FFF_FFFF, 1'b0, 1'b0, '0);
        add_row(32'sh8000_0000, 1'b0, 1'b0, '0);
        add_row(32'sd1,         1'b1, 1'b0, '0);
        // Descending positives
        add_row(32'sd4,         1'b0, 1'b0, '0);
        add_row(32'sd3,         1'b0, 1'b0, '0);
        add_row(32'sd2,         1'b0, 1'b0, '0);
        add_row(32'sd1,         1'b1, 1'b0, '0);
        // No positives at all
        add_row(-32'sd5,        1'b0, 1'b0, '0);
        add_row(32'sd0,         1'b0, 1'b0, '0);
        add_row(-32'sd1,        1'b1, 1'b0, '0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed rows
        foreach (directed_rows[r]) begin
            send_element(directed_rows[r].item);
            sort_list_element(directed_rows[r].item);
            if (directed_rows[r].typed) begin
                typed_res = '{value_res: directed_rows[r].exp_value, last_res: 1'b1,
                              overflow: 1'b0};
                expected_list_out.push_back(typed_res);
            end else begin
                queue_model_results();
            end
        end

        // Random lists: one full, one overflowing, then mostly short ones
        sent    = 0;
        list_no = 0;
        while (sent < RAND_ITEMS) begin
            if (list_no == 0)
                len = LIST_CAP;
            else if (list_no == 1)
                len = LIST_CAP + 3;
            else begin
                case ($urandom_range(0, 19))
                    17:      len = LIST_CAP;
                    18, 19:  len = $urandom_range(LIST_CAP + 1, LIST_CAP + 8);
                    14, 15, 16: len = $urandom_range(9, LIST_CAP - 1);
                    default: len = $urandom_range(1, 8);
                endcase
            end
            for (k = 0; k < len; k++) begin
                it.value = draw_value();
                it.last  = (k == len - 1);
                send_element(it);
                sort_list_element(it);
                queue_model_results();
                sent++;
            end
            list_no++;
        end

        @(negedge i_clk);
        in_valid = 1'b0;

        // Drain, then keep watching for stray results
        while (expected_list_out.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_list_out.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver: random stall, then take and check one result
    initial begin
        int hold;
        t_out_item exp_res;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            draw_wait(rx_calm, hold);
            if (hold > 0) begin
                out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            out_stall = 1'b0;
            do @(posedge i_clk); while (!out_valid);
            if (expected_list_out.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORT)
                    $display("%0t: unexpected result value=%0d last=%0b ovf=%0b", $time,
                             out_item.value_res, out_item.last_res, out_item.overflow);
            end else begin
                exp_res = expected_list_out.pop_front();
                if (out_item.value_res !== exp_res.value_res ||
                    out_item.last_res  !== exp_res.last_res  ||
                    out_item.overflow  !== exp_res.overflow) begin
                    errors++;
                    if (errors <= MAX_REPORT)
                        $display("%0t: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 $time, exp_res.value_res, exp_res.last_res,
                                 exp_res.overflow, out_item.value_res,
                                 out_item.last_res, out_item.overflow);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
